// File: sv/ems_pkg.sv
// Shared widths, register indexes, reset values and request types for the smoother.
`timescale 1ns / 1ps
package ems_pkg;

  localparam int SAMPLE_W   = 48;
  localparam int COUNT_W    = 8;
  localparam int TOTAL_W    = 56;
  localparam int ALPHA_W    = 16;
  localparam int ABOVE_W    = 47;
  localparam int BELOW_W    = 16;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int PROD_W     = DIFF_W + ALPHA_W;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 47;

  localparam logic [CFG_ADDR_W-1:0] REG_WARMUP = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ALPHA  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ABOVE  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BELOW  = 2'd3;

  localparam logic [COUNT_W-1:0] WARMUP_RST = 8'd50;
  localparam logic [ALPHA_W-1:0] ALPHA_RST  = 16'd21845;
  localparam logic [ABOVE_W-1:0] ABOVE_RST  = 47'd65536000000;
  localparam logic [BELOW_W-1:0] BELOW_RST  = 16'd7;

  typedef struct packed {
    logic               start;
    logic [TOTAL_W-1:0] dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                     start;
    logic [ALPHA_W-1:0]       alpha;
    logic signed [DIFF_W-1:0] diff;
  } mac_req_t;

endpackage

// File: sv/ems_serial_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module ems_serial_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ems_pkg::div_req_t            req,
  output logic                         done,
  output logic [ems_pkg::TOTAL_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(ems_pkg::TOTAL_W);

  logic [ems_pkg::TOTAL_W-1:0] num_r;
  logic [ems_pkg::COUNT_W-1:0] div_r;
  logic [ems_pkg::COUNT_W-1:0] rem_r;
  logic [ems_pkg::COUNT_W-1:0] rem_nxt;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [ems_pkg::COUNT_W:0]   trial;
  logic                        fits;

  always_comb begin
    trial   = {rem_r, num_r[ems_pkg::TOTAL_W-1]};
    fits    = trial >= {1'b0, div_r};
    rem_nxt = fits ? ems_pkg::COUNT_W'(trial - {1'b0, div_r})
                   : trial[ems_pkg::COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ems_pkg::TOTAL_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend out at the top and the quotient bits in at the bottom.
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.dividend;
      div_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[ems_pkg::TOTAL_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

// File: sv/ems_serial_mac.sv
// Shift-add multiplier of the weight by the signed difference, one weight bit per cycle.
`timescale 1ns / 1ps
module ems_serial_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ems_pkg::mac_req_t                 req,
  output logic                              done,
  output logic signed [ems_pkg::PROD_W-1:0] product
);

  localparam int CNT_W = $clog2(ems_pkg::ALPHA_W);

  logic signed [ems_pkg::PROD_W-1:0] acc_r;
  logic signed [ems_pkg::PROD_W-1:0] acc_nxt;
  logic [ems_pkg::ALPHA_W-1:0]       alpha_r;
  logic signed [ems_pkg::DIFF_W-1:0] diff_r;
  logic [CNT_W-1:0]                  cnt_r;
  logic                              busy_r;
  logic                              done_r;

  // Take the weight most significant bit first.
  always_comb begin
    acc_nxt = acc_r <<< 1;
    if (alpha_r[ems_pkg::ALPHA_W-1]) begin
      acc_nxt = acc_nxt + {{ems_pkg::ALPHA_W{diff_r[ems_pkg::DIFF_W-1]}}, diff_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ems_pkg::ALPHA_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r   <= '0;
      alpha_r <= req.alpha;
      diff_r  <= req.diff;
    end else if (busy_r) begin
      acc_r   <= acc_nxt;
      alpha_r <= {alpha_r[ems_pkg::ALPHA_W-2:0], 1'b0};
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// File: sv/ema_smoother_with_warmup.sv
// Top level: warm-up mean and exponential moving average of a sample stream.
//
//  channel | direction | tdata / data             | tuser / addr
//  in_     | slave     | sample[47:0]             | no_value[0]
//  out_    | master    | smoothed[47:0]           | warming_up, output_valid, sample_replaced
//  cfg_    | slave     | cfg_data[46:0]           | cfg_addr[1:0] register index
//
// One item at a time. A warm-up item waits on the serial divider that yields
// 56 quotient bits (the divider is not started while no sample has been taken yet);
// a run item waits on the 16 weight bits of the serial multiplier.
// The next request is taken in the cycle after the result is loaded.
// The output register lets a new request enter while a result waits to be taken.
// Reset (synchronous, active low) loads register defaults and clears the state.
// Configuration writes are always ready and take effect in the next cycle.
`timescale 1ns / 1ps
module ema_smoother_with_warmup (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ems_pkg::SAMPLE_W-1:0]       in_tdata,   // sample[47:0]
  input  logic [0:0]                         in_tuser,   // no_value[0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ems_pkg::SAMPLE_W-1:0]       out_tdata,  // smoothed[47:0]
  output logic [2:0]                         out_tuser,  // warming_up[0], output_valid[1],
                                                         // sample_replaced[2]
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ems_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ems_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_EVAL  = 4'd1;
  localparam logic [3:0] ST_WARM  = 4'd2;
  localparam logic [3:0] ST_DSET  = 4'd3;
  localparam logic [3:0] ST_DGO   = 4'd4;
  localparam logic [3:0] ST_DWAIT = 4'd5;
  localparam logic [3:0] ST_RUN   = 4'd6;
  localparam logic [3:0] ST_MGO   = 4'd7;
  localparam logic [3:0] ST_MWAIT = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  localparam int SW = ems_pkg::SAMPLE_W;
  localparam int TW = ems_pkg::TOTAL_W;
  localparam int CW = ems_pkg::COUNT_W;
  localparam int DW = ems_pkg::DIFF_W;
  localparam int PW = ems_pkg::PROD_W;

  logic [3:0]                 st_r;
  logic [CW-1:0]              warmup_r;
  logic [ems_pkg::ALPHA_W-1:0] alpha_r;
  logic [ems_pkg::ABOVE_W-1:0] above_r;
  logic [ems_pkg::BELOW_W-1:0] below_r;

  logic [CW-1:0]              remaining_r;
  logic [TW-1:0]              total_r;
  logic [SW-1:0]              baseline_r;
  logic [SW-1:0]              last_r;

  logic [SW-1:0]              sample_r;
  logic                       nov_r;
  logic                       rej_r;
  logic                       warm_r;
  logic [TW-1:0]              tmag_r;
  logic [CW-1:0]              d_r;
  logic signed [DW-1:0]       diff_r;
  logic [SW-1:0]              res_r;
  logic                       valid_r;

  logic                       out_tvalid_r;
  logic [SW-1:0]              out_data_r;
  logic [2:0]                 out_user_r;

  logic [SW-1:0]              smag;
  logic                       rejected;
  logic [SW-1:0]              xs;
  logic [SW-1:0]              quo_lo;
  logic [SW-1:0]              mean;
  logic [PW:0]                ema_sum;

  ems_pkg::div_req_t          div_req;
  ems_pkg::mac_req_t          mac_req;
  logic                       div_done;
  logic [TW-1:0]              div_quo;
  logic                       mac_done;
  logic signed [PW-1:0]       mac_prod;

  assign in_tready = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    smag     = sample_r[SW-1] ? SW'('0 - sample_r) : sample_r;
    rejected = nov_r || (smag > {1'b0, above_r})
               || (smag < {{(SW - ems_pkg::BELOW_W){1'b0}}, below_r});
    xs       = rej_r ? baseline_r : sample_r;
    quo_lo   = div_quo[SW-1:0];
    mean     = total_r[TW-1] ? SW'('0 - quo_lo) : quo_lo;
    // (last << 16) + 32768 + alpha * (x - last)
    ema_sum  = {{2{last_r[SW-1]}}, last_r, 16'h8000} + {mac_prod[PW-1], mac_prod};
  end

  always_comb begin
    div_req.start    = (st_r == ST_DGO) && (d_r != '0);
    div_req.dividend = tmag_r + {{(TW - CW + 1){1'b0}}, d_r[CW-1:1]};
    div_req.divisor  = d_r;
    mac_req.start    = (st_r == ST_MGO);
    mac_req.alpha    = alpha_r;
    mac_req.diff     = diff_r;
  end

  ems_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  ems_serial_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mac_req),
    .done    (mac_done),
    .product (mac_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      warmup_r     <= ems_pkg::WARMUP_RST;
      alpha_r      <= ems_pkg::ALPHA_RST;
      above_r      <= ems_pkg::ABOVE_RST;
      below_r      <= ems_pkg::BELOW_RST;
      remaining_r  <= ems_pkg::WARMUP_RST;
      total_r      <= '0;
      baseline_r   <= '0;
      last_r       <= '0;
    end else begin
      // a taken result clears the register, unless a finished result reloads it in the same cycle
      if (out_tvalid_r && out_tready && (st_r != ST_FIN)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            sample_r <= in_tdata;
            nov_r    <= in_tuser[0];
            st_r     <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          rej_r  <= rejected;
          warm_r <= (remaining_r != '0);
          st_r   <= (remaining_r != '0) ? ST_WARM : ST_RUN;
        end
        ST_WARM: begin
          if (!rej_r) begin
            remaining_r <= remaining_r - 1'b1;
            total_r     <= total_r + {{(TW - SW){sample_r[SW-1]}}, sample_r};
          end
          st_r <= ST_DSET;
        end
        ST_DSET: begin
          tmag_r <= total_r[TW-1] ? TW'('0 - total_r) : total_r;
          d_r    <= warmup_r - remaining_r;
          st_r   <= ST_DGO;
        end
        ST_DGO: begin
          if (d_r == '0) begin
            // No sample taken yet: report zero, marked invalid.
            res_r   <= '0;
            valid_r <= 1'b0;
            if (remaining_r == '0) begin
              baseline_r <= '0;
              last_r     <= '0;
            end
            st_r <= ST_FIN;
          end else begin
            st_r <= ST_DWAIT;
          end
        end
        ST_DWAIT: begin
          if (div_done) begin
            res_r   <= mean;
            valid_r <= 1'b1;
            if (remaining_r == '0) begin
              baseline_r <= mean;
              last_r     <= mean;
            end
            st_r <= ST_FIN;
          end
        end
        ST_RUN: begin
          diff_r <= $signed({xs[SW-1], xs}) - $signed({last_r[SW-1], last_r});
          st_r   <= ST_MGO;
        end
        ST_MGO: begin
          st_r <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (mac_done) begin
            res_r   <= ema_sum[SW+15:16];
            last_r  <= ema_sum[SW+15:16];
            valid_r <= 1'b1;
            st_r    <= ST_FIN;
          end
        end
        ST_FIN: begin
          // Hold the result until the output register is free.
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_data_r   <= res_r;
            out_user_r   <= {rej_r, valid_r, warm_r};
            st_r         <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
      if (cfg_valid) begin
        unique case (cfg_addr)
          ems_pkg::REG_WARMUP: begin
            warmup_r    <= cfg_data[CW-1:0];
            remaining_r <= cfg_data[CW-1:0];
            total_r     <= '0;
          end
          ems_pkg::REG_ALPHA: alpha_r <= cfg_data[ems_pkg::ALPHA_W-1:0];
          ems_pkg::REG_ABOVE: above_r <= cfg_data[ems_pkg::ABOVE_W-1:0];
          ems_pkg::REG_BELOW: below_r <= cfg_data[ems_pkg::BELOW_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (st_r == ST_EVAL))
    else $error("accepted request did not enter evaluation");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == ST_DWAIT))
    else $error("divider finished outside its wait state");

  a_mac_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (st_r == ST_MWAIT))
    else $error("multiplier finished outside its wait state");

  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_FIN) && (!out_tvalid_r || out_tready)) |=> (out_tvalid_r && in_tready))
    else $error("finished result was not loaded into the output register");
`endif

endmodule
